// ----- rtl/fir_filter_overlap_add_macros.svh -----
// Assertion helpers for the top-level RTL.
`ifndef FIR_FILTER_OVERLAP_ADD_MACROS_SVH
`define FIR_FILTER_OVERLAP_ADD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FOLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FOLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fir_ola_pkg.sv -----
`default_nettype none

package fir_ola_pkg;

  localparam int DATA_W      = 16;
  localparam int TAP_IDX_W   = 6;
  localparam int TAP_CNT_W   = 7;
  localparam int ACC_W       = 41;  // holds 512 full-scale products
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ROUND_SHIFT = DATA_W - 1;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = TAP_CNT_W'(64);
  localparam logic [TAP_CNT_W-1:0] WARM_MAX      = TAP_CNT_W'(127);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (ROUND_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(1 << 30);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(1 << 30);

  localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

  // request action codes
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // register word index (paddr[2])
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fola_state_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef struct packed {
    logic done;
  } mac_stat_t;

endpackage

`default_nettype wire

// ----- rtl/fir_ola_req_if.sv -----
`default_nettype none

interface fir_ola_req_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       action;
  logic        [fir_ola_pkg::TAP_IDX_W-1:0]   tap_index;
  logic signed [fir_ola_pkg::DATA_W-1:0]      value;

  modport source (output valid, action, tap_index, value, input ready);
  modport sink   (input valid, action, tap_index, value, output ready);
endinterface

`default_nettype wire

// ----- rtl/fir_ola_res_if.sv -----
`default_nettype none

interface fir_ola_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fir_ola_pkg::DATA_W-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

`default_nettype wire

// ----- rtl/fir_ola_mac.sv -----
`default_nettype none

// Multiply, accumulate, then round to Q1.15 and saturate.
module fir_ola_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fir_ola_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [fir_ola_pkg::DATA_W-1:0] coef_i,
  input  logic signed [fir_ola_pkg::DATA_W-1:0] smp_i,
  output fir_ola_pkg::mac_stat_t                stat_o,
  output logic signed [fir_ola_pkg::DATA_W-1:0] filtered_o
);

  logic signed [fir_ola_pkg::PROD_W-1:0] prod_q;
  fir_ola_pkg::mac_ctrl_t                c1_q;
  logic signed [fir_ola_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [fir_ola_pkg::ACC_W-1:0]  rnd;
  logic                                  done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q   <= '0;
      done_q <= 1'b0;
    end else begin
      c1_q   <= ctrl_i;
      done_q <= c1_q.valid & c1_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * smp_i;
    if (c1_q.valid) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    if (c1_q.first) begin
      acc_d = fir_ola_pkg::ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + fir_ola_pkg::ACC_W'(prod_q);
    end
  end

  // add half an LSB, floor, clip to the Q1.15 range
  assign rnd = acc_q + fir_ola_pkg::RND_HALF;

  always_comb begin
    if (rnd >= fir_ola_pkg::SAT_HI) begin
      filtered_o = fir_ola_pkg::OUT_MAX;
    end else if (rnd < fir_ola_pkg::SAT_LO) begin
      filtered_o = fir_ola_pkg::OUT_MIN;
    end else begin
      filtered_o = rnd[fir_ola_pkg::ROUND_SHIFT + fir_ola_pkg::DATA_W - 1:
                       fir_ola_pkg::ROUND_SHIFT];
    end
  end

  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ----- rtl/fir_filter_overlap_add.sv -----
// Direct-form FIR filter, Q1.15 in and out, up to MAX_TAPS taps. A request with
// action 1 loads one coefficient; one with action 0 pushes a sample into the
// history and, once the filter has warmed up (the first active taps - 1
// samples give no result), returns the rounded, saturated sum of coefficient
// times delayed sample. Coefficients and history sit in two single-port-write,
// registered-read memories; one multiply-accumulate per tap per cycle, so a
// filtering sample occupies the block until the read-multiply-accumulate walk
// over the memories is done and its result is in the output register. After
// a load or a warm-up sample the block stays idle for the next request. After
// reset a clearing pass zeroes both memories before the first request is
// taken; tap_count may be written meanwhile. A finished result waits in an
// output register and the next request is taken while it does.
`default_nettype none

module fir_filter_overlap_add #(
  parameter int MAX_TAPS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fir_ola_req_if.sink          smp_i,
  fir_ola_res_if.source        res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

`include "fir_filter_overlap_add_macros.svh"

  localparam int PW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [PW-1:0] LAST_IDX = PW'(MAX_TAPS - 1);

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic [fir_ola_pkg::TAP_CNT_W-1:0] tap_count_q;
  logic                              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready &
                  (paddr[2] == fir_ola_pkg::REG_TAP_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fir_ola_pkg::TAP_COUNT_RST;
    end else if (cfg_we) begin
      tap_count_q <= pwdata[fir_ola_pkg::TAP_CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == fir_ola_pkg::REG_TAP_COUNT) begin
      prdata = 32'(tap_count_q);
    end else begin
      prdata = '0;
    end
  end

  // Last active tap index: a count of zero acts as one tap, a count above
  // the store depth as the full store.
  logic [PW-1:0] taps_m1;

  always_comb begin
    if (tap_count_q == '0) begin
      taps_m1 = '0;
    end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
      taps_m1 = LAST_IDX;
    end else begin
      taps_m1 = PW'(32'(tap_count_q) - 32'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  fir_ola_pkg::fola_state_e state_q, state_d;
  fir_ola_pkg::mac_stat_t   mac_stat;

  logic          smp_acc, is_load, is_filter, warm_hold, out_free;
  logic          smp_ready, issue, clr_en, load_out;
  logic          out_valid_q;
  logic [PW-1:0] clr_q;
  logic [PW-1:0] wp_q, wp_nxt;
  logic [PW-1:0] rp_q;
  logic [PW-1:0] k_q;
  logic [fir_ola_pkg::TAP_CNT_W-1:0] warm_q;

  assign smp_acc   = smp_i.valid & smp_i.ready;
  assign is_load   = smp_i.action == fir_ola_pkg::ACT_LOAD;
  assign is_filter = smp_i.action == fir_ola_pkg::ACT_FILTER;
  assign warm_hold = 32'(warm_q) < 32'(taps_m1);
  assign out_free  = ~out_valid_q | res_o.ready;
  assign wp_nxt    = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fir_ola_pkg::ST_CLEAR: begin
        if (clr_q == LAST_IDX) begin
          state_d = fir_ola_pkg::ST_IDLE;
        end
      end
      fir_ola_pkg::ST_IDLE: begin
        if (smp_acc && is_filter && !warm_hold) begin
          state_d = fir_ola_pkg::ST_RUN;
        end
      end
      fir_ola_pkg::ST_RUN: begin
        if (k_q == taps_m1) begin
          state_d = fir_ola_pkg::ST_DRAIN;
        end
      end
      fir_ola_pkg::ST_DRAIN: begin
        if (mac_stat.done) begin
          state_d = fir_ola_pkg::ST_DONE;
        end
      end
      fir_ola_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = fir_ola_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fir_ola_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    smp_ready = 1'b0;
    issue     = 1'b0;
    clr_en    = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      fir_ola_pkg::ST_CLEAR: clr_en    = 1'b1;
      fir_ola_pkg::ST_IDLE:  smp_ready = 1'b1;
      fir_ola_pkg::ST_RUN:   issue     = 1'b1;
      fir_ola_pkg::ST_DRAIN: ;
      fir_ola_pkg::ST_DONE:  load_out  = out_free;
      default: ;
    endcase
  end

  assign smp_i.ready = smp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fir_ola_pkg::ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
      k_q     <= '0;
      warm_q  <= '0;
    end else begin
      state_q <= state_d;
      if (clr_en) begin
        clr_q <= clr_q + 1'b1;
      end
      if (smp_acc && is_filter) begin
        // newest sample goes one slot on; the walk starts there
        wp_q <= wp_nxt;
        rp_q <= wp_nxt;
        k_q  <= '0;
        if (warm_hold && (warm_q != fir_ola_pkg::WARM_MAX)) begin
          warm_q <= warm_q + 1'b1;
        end
      end else if (issue) begin
        rp_q <= (rp_q == '0) ? LAST_IDX : rp_q - 1'b1;
        k_q  <= k_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient and history memories. The history is a ring: wp_q holds the
  // newest sample and older ones sit at falling addresses. A sample written at
  // the accept edge is read back no earlier than the next cycle.
  // ---------------------------------------------------------------------------
  logic [fir_ola_pkg::DATA_W-1:0] coef_mem [MAX_TAPS];
  logic [fir_ola_pkg::DATA_W-1:0] hist_mem [MAX_TAPS];
  logic [fir_ola_pkg::DATA_W-1:0] coef_rd_q, hist_rd_q;
  logic [fir_ola_pkg::DATA_W-1:0] coef_wd, hist_wd;
  logic [PW-1:0]                  coef_wa, hist_wa;
  logic                           coef_we, hist_we, slot_ok;

  assign slot_ok = 32'(smp_i.tap_index) < 32'(MAX_TAPS);
  assign coef_we = clr_en | (smp_acc & is_load & slot_ok);
  assign coef_wa = clr_en ? clr_q : PW'(32'(smp_i.tap_index));
  assign coef_wd = clr_en ? '0 : smp_i.value;
  assign hist_we = clr_en | (smp_acc & is_filter);
  assign hist_wa = clr_en ? clr_q : wp_nxt;
  assign hist_wd = clr_en ? '0 : smp_i.value;

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_q <= coef_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[rp_q];
  end

  // Control travelling alongside the read data.
  fir_ola_pkg::mac_ctrl_t ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q.valid <= issue;
      ctrl_q.first <= k_q == '0;
      ctrl_q.last  <= k_q == taps_m1;
    end
  end

  logic signed [fir_ola_pkg::DATA_W-1:0] mac_filtered;

  fir_ola_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_q),
    .coef_i     (coef_rd_q),
    .smp_i      (hist_rd_q),
    .stat_o     (mac_stat),
    .filtered_o (mac_filtered)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [fir_ola_pkg::DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= mac_filtered;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.filtered = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FOLA_ASSERT_IMP(a_done_in_drain, clk_i, rst_ni, mac_stat.done,
                   state_q == fir_ola_pkg::ST_DRAIN, "mac finished outside drain")
  `FOLA_ASSERT_IMP(a_clear_quiet, clk_i, rst_ni, state_q == fir_ola_pkg::ST_CLEAR,
                   !out_valid_q && !ctrl_q.valid, "activity during clearing pass")
  `FOLA_ASSERT_IMP(a_issue_bound, clk_i, rst_ni, issue, k_q <= taps_m1,
                   "tap walk beyond active taps")
  `FOLA_ASSERT_NXT(a_last_tagged, clk_i, rst_ni, issue && (k_q == taps_m1),
                   ctrl_q.valid && ctrl_q.last, "last tap not tagged")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import fir_ola_pkg::*;

  localparam int MAX_TAPS    = 64;
  localparam int ITEM_TOTAL  = 1750;
  localparam int DRAIN_CYC   = 100;       // longer than a full-length filter pass
  localparam int LONG_HOLD   = 2000;      // receiver back-pressure stretch
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [2:0] TAP_COUNT_ADDR = {REG_TAP_COUNT, 2'b00};

  localparam longint ACC_HI = (longint'(1) << 39) - 1;
  localparam longint ACC_LO = -(longint'(1) << 39);
  localparam longint Q30    = longint'(1) << 30;

  typedef struct {
    logic                    act;
    logic [TAP_IDX_W-1:0]    slot;
    logic signed [DATA_W-1:0] val;
  } req_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fir_ola_req_if smp_if ();
  fir_ola_res_if res_if ();

  fir_filter_overlap_add #(
    .MAX_TAPS (MAX_TAPS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .smp_i   (smp_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the filter: taps, delay line, warm-up counter and tap count
  logic signed [DATA_W-1:0] coef_mem [MAX_TAPS];
  logic signed [DATA_W-1:0] hist_mem [MAX_TAPS];
  int                       warm_cnt;
  logic [TAP_CNT_W-1:0]     tap_cfg;

  logic signed [DATA_W-1:0] filtered_q [$];   // outputs still owed by the block
  req_item_t                pend_q [$];       // requests not yet offered

  int   queued_cnt;
  int   taken_cnt;
  int   errors;
  int   cycle_cnt;
  logic tx_pace;
  logic rx_pace;
  int   tx_gap;
  int   rx_wait;
  int   rx_taken;
  req_item_t                tx_item;
  logic signed [DATA_W-1:0] want;

  // Idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_taps(input logic [TAP_CNT_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_TAPS) return MAX_TAPS;
    return n;
  endfunction

  // Work out what one accepted request should produce
  function automatic void fir_predict(input logic act, input logic [TAP_IDX_W-1:0] slot,
                                      input logic signed [DATA_W-1:0] val);
    int     k;
    int     taps;
    longint acc;
    longint rnd;
    if (act == ACT_LOAD) begin
      coef_mem[slot] = val;
      return;
    end
    for (k = MAX_TAPS - 1; k > 0; k--) hist_mem[k] = hist_mem[k-1];
    hist_mem[0] = val;
    taps = eff_taps(tap_cfg);
    // warm-up: sample still enters the delay line, but no output
    if (warm_cnt < taps - 1) begin
      if (warm_cnt < int'(WARM_MAX)) warm_cnt++;
      return;
    end
    acc = 0;
    for (k = 0; k < taps; k++) acc += longint'(coef_mem[k]) * longint'(hist_mem[k]);
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    // round half up to Q1.15, then saturate
    rnd = acc + 16384;
    if (rnd >= Q30)       filtered_q.push_back(OUT_MAX);
    else if (rnd < -Q30)  filtered_q.push_back(OUT_MIN);
    else                  filtered_q.push_back(DATA_W'(rnd >>> 15));
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return OUT_MAX;
      1:       return OUT_MIN;
      2:       return '0;
      3:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic act, input logic [TAP_IDX_W-1:0] slot,
                            input logic signed [DATA_W-1:0] val);
    req_item_t it;
    it.act  = act;
    it.slot = slot;
    it.val  = val;
    pend_q.push_back(it);
    queued_cnt++;
  endtask

  // APB transfer: setup cycle, access cycle, done when pready is seen
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_taps(input logic [TAP_CNT_W-1:0] n);
    logic [31:0] rd;
    apb_access(1'b1, TAP_COUNT_ADDR, 32'(n), rd);
    tap_cfg = n;
    apb_access(1'b0, TAP_COUNT_ADDR, 32'd0, rd);
    if (rd[TAP_CNT_W-1:0] !== n) begin
      errors++;
      $display("%0t: tap_count readback expected %0d, actual %0d", $time, n,
               rd[TAP_CNT_W-1:0]);
    end
  endtask

  // Block is idle once every request is in and every output is out; loads and
  // warm-up samples give nothing back, so allow a full filter pass on top.
  task automatic drain_wait();
    while (taken_cnt != queued_cnt || filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Request driver: valid stays up until taken, gaps only between requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
      tx_gap       <= 0;
    end else if (!smp_if.valid || smp_if.ready) begin
      if (tx_gap != 0) begin
        smp_if.valid <= 1'b0;
        tx_gap       <= tx_gap - 1;
      end else if (pend_q.size() != 0) begin
        tx_item = pend_q.pop_front();
        smp_if.valid     <= 1'b1;
        smp_if.action    <= tx_item.act;
        smp_if.tap_index <= tx_item.slot;
        smp_if.value     <= tx_item.val;
        tx_gap           <= tx_pace ? idle_len() : 0;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus two long hold-offs so that the output
  // register fills and the block has to push back on its requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_wait      <= 0;
      rx_taken     <= 0;
    end else begin
      if (res_if.valid && res_if.ready) rx_taken <= rx_taken + 1;
      if (rx_wait != 0) begin
        rx_wait      <= rx_wait - 1;
        res_if.ready <= 1'b0;
      end else if (res_if.valid && res_if.ready && (rx_taken == 399 || rx_taken == 1199)) begin
        rx_wait      <= LONG_HOLD;
        res_if.ready <= 1'b0;
      end else if (rx_pace && $urandom_range(0, 99) < 25) begin
        rx_wait      <= idle_len();
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check outputs against the oldest expectation, then feed the
  // shadow model with whatever request went in at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: filtered expected none, actual %0d", $time, res_if.filtered);
        end else begin
          want = filtered_q.pop_front();
          if (res_if.filtered !== want) begin
            errors++;
            $display("%0t: filtered expected %0d, actual %0d", $time, want,
                     res_if.filtered);
          end
        end
      end
      if (smp_if.valid && smp_if.ready) begin
        fir_predict(smp_if.action, smp_if.tap_index, smp_if.value);
        taken_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[fir_filter_overlap_add] ERROR");
      $finish;
    end
  end

  initial begin
    int                   phase;
    int                   n_items;
    int                   eff;
    int                   r;
    logic [TAP_CNT_W-1:0] n_taps;

    // everything known from time zero
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    smp_if.valid     = 1'b0;
    smp_if.action    = ACT_FILTER;
    smp_if.tap_index = '0;
    smp_if.value     = '0;
    res_if.ready     = 1'b0;
    tx_pace          = 1'b0;
    rx_pace          = 1'b0;
    cycle_cnt        = 0;
    queued_cnt       = 0;
    taken_cnt        = 0;
    errors           = 0;
    warm_cnt         = 0;
    tap_cfg          = TAP_COUNT_RST;
    for (int k = 0; k < MAX_TAPS; k++) begin
      coef_mem[k] = '0;
      hist_mem[k] = '0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero taps behaves as one tap, so no warm-up; written during the clear
    set_taps('0);
    queue_item(ACT_LOAD,   6'd0,  OUT_MAX);
    queue_item(ACT_FILTER, 6'd0,  OUT_MAX);
    queue_item(ACT_FILTER, 6'd63, OUT_MIN);
    queue_item(ACT_FILTER, 6'd0,  16'sd0);
    queue_item(ACT_FILTER, 6'd21, 16'sd1);
    queue_item(ACT_LOAD,   6'd0,  OUT_MIN);
    queue_item(ACT_FILTER, 6'd0,  OUT_MIN);   // -1 * -1 clips to +max
    queue_item(ACT_FILTER, 6'd0,  OUT_MAX);
    queue_item(ACT_LOAD,   6'd63, OUT_MAX);   // slot outside the active taps
    queue_item(ACT_FILTER, 6'd42, 16'sh5555);
    drain_wait();

    // Two taps: first sample is a warm-up one, then both clip directions
    set_taps(7'd2);
    queue_item(ACT_LOAD,   6'd1,  OUT_MIN);
    queue_item(ACT_LOAD,   6'd0,  OUT_MIN);
    queue_item(ACT_FILTER, 6'd0,  OUT_MIN);
    queue_item(ACT_FILTER, 6'd0,  OUT_MIN);   // large positive sum
    queue_item(ACT_LOAD,   6'd0,  OUT_MAX);
    queue_item(ACT_LOAD,   6'd1,  OUT_MAX);
    queue_item(ACT_FILTER, 6'd0,  OUT_MIN);   // large negative sum
    queue_item(ACT_FILTER, 6'd0,  OUT_MAX);
    queue_item(ACT_FILTER, 6'd0,  OUT_MAX);
    queue_item(ACT_LOAD,   6'd1,  16'sd0);
    queue_item(ACT_FILTER, 6'd0,  -16'sd3);
    drain_wait();

    // Random phases. Early ones walk the tap count through its extremes:
    // raising it resumes warm-up up to the new length without clearing.
    phase = 0;
    while (queued_cnt < ITEM_TOTAL) begin
      case (phase)
        0:       n_taps = 7'd64;
        1:       n_taps = 7'd127;
        2:       n_taps = 7'd1;
        3:       n_taps = 7'd0;
        4:       n_taps = 7'd65;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 65)      n_taps = TAP_CNT_W'($urandom_range(1, 8));
          else if (r < 85) n_taps = TAP_CNT_W'($urandom_range(9, 63));
          else if (r < 95) n_taps = TAP_CNT_W'($urandom_range(64, 127));
          else             n_taps = '0;
        end
      endcase
      set_taps(n_taps);
      eff = eff_taps(n_taps);

      // first random phase runs flat out on both sides
      @(posedge clk_i);
      tx_pace <= (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_pace <= (phase != 0) && ($urandom_range(0, 3) != 0);

      if (phase == 0)    n_items = 200;
      else if (eff > 16) n_items = $urandom_range(60, 100);
      else               n_items = $urandom_range(100, 200);

      repeat (n_items) begin
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 3) == 0)
            queue_item(ACT_LOAD, TAP_IDX_W'($urandom), rand_value());
          else
            queue_item(ACT_LOAD, TAP_IDX_W'($urandom_range(0, eff - 1)), rand_value());
        end else begin
          queue_item(ACT_FILTER, TAP_IDX_W'($urandom), rand_value());
        end
      end
      drain_wait();
      phase++;
    end

    if (errors == 0) begin
      $display("[fir_filter_overlap_add] OK");
    end else begin
      $display("[fir_filter_overlap_add] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fir_ola_pkg.sv
rtl/fir_ola_req_if.sv
rtl/fir_ola_res_if.sv
rtl/fir_ola_mac.sv
rtl/fir_filter_overlap_add.sv
bench/tb_top.sv
